/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Small wrappers around concurrent assertions, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/core/ftrc_pkg.sv */
// ----------------------------------------------------------------------------
// ftrc_pkg
// Shared types and constants of the rule classifier.
// ----------------------------------------------------------------------------
package ftrc_pkg;
    localparam int MaxRules = 64;
    localparam int IdxW = $clog2(MaxRules);
    localparam int CntW = $clog2(MaxRules + 1);

    localparam logic [1:0] CmdAdd = 2'd0;
    localparam logic [1:0] CmdDel = 2'd1;
    localparam logic [1:0] CmdCls = 2'd2;

    localparam logic [2:0] StAdded = 3'd0;
    localparam logic [2:0] StDup = 3'd1;
    localparam logic [2:0] StUpdated = 3'd2;
    localparam logic [2:0] StDeleted = 3'd3;
    localparam logic [2:0] StNotFound = 3'd4;
    localparam logic [2:0] StFull = 3'd5;
    localparam logic [2:0] StClassified = 3'd6;

    localparam logic [7:0] ProtoTcp = 8'd6;
    localparam logic [7:0] ProtoUdp = 8'd17;
    localparam logic [7:0] ProtoIcmp = 8'd1;

    localparam logic [1:0] RpTcp = 2'd0;
    localparam logic [1:0] RpUdp = 2'd1;
    localparam logic [1:0] RpIcmp = 2'd2;

    typedef struct packed {
        logic [9:0]  id;
        logic [2:0]  kind;
        logic [31:0] sa;
        logic [31:0] da;
        logic [31:0] ports;
    } t_rule;
endpackage

/* rtl/core/five_tuple_rule_classifier.sv */
// An unused command answers in the cycle after it is taken.
// Throughput: one item at a time; the next is taken the cycle after the result is taken.
// The rate is set by the single-port rule memory.
// Reset clears the rule count and control state; the memory is not cleared.
// ----------------------------------------------------------------------------
// five_tuple_rule_classifier
// Sorted five-tuple rule table with add, delete and first-match classify.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module five_tuple_rule_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_rule_id,
    input  logic        i_rule_action,
    input  logic [1:0]  i_rule_protocol,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_sport,
    input  logic [15:0] i_dport,
    input  logic [7:0]  i_ip_protocol,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_verdict,
    output logic        o_matched,
    output logic [9:0]  o_matched_id
);
    import ftrc_pkg::*;

    // The sequencer: SCAN reads entries in order (the read data is registered,
    // so a WAIT cycle sits between each address and its compare); SHIFT moves
    // entries one place up or down through the same single-port memory.
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAIT, S_SHUP, S_SHDN, S_WRITE, S_OUT
    } t_state;

    t_state r_state;
    t_rule mem [MaxRules];
    t_rule r_rd;
    t_rule r_new;
    logic [1:0] r_cmd;
    logic [7:0] r_ipp;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_i;      // entry being looked at
    logic [CntW-1:0] r_j;      // shift cursor
    logic [CntW-1:0] r_pos;
    logic [2:0] r_status;
    logic r_verdict, r_matched;
    logic [9:0] r_mid;
    logic r_sh_rd;             // shift step phase: read issued, write next

    // Memory port: one address per cycle, registered read.
    logic [IdxW-1:0] m_addr;
    logic m_we;
    t_rule m_wd;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_addr] <= m_wd;
        end
        r_rd <= mem[m_addr];
    end

    logic hit;
    ftrc_match u_match (
        .i_rule(r_rd), .i_sa(r_new.sa), .i_da(r_new.da),
        .i_sp(r_new.ports[31:16]), .i_dp(r_new.ports[15:0]),
        .i_ipp(r_ipp), .o_hit(hit)
    );

    logic same_body;
    assign same_body = (r_rd.kind == r_new.kind) && (r_rd.sa == r_new.sa)
        && (r_rd.da == r_new.da) && (r_rd.ports == r_new.ports);

    always_comb begin
        m_addr = r_i[IdxW-1:0];
        m_we = 1'b0;
        m_wd = r_new;
        case (r_state)
            S_SHUP: begin
                // Insert: entry j-1 moves to j, working downwards.
                m_addr = r_sh_rd ? r_j[IdxW-1:0] : IdxW'(r_j - 1'b1);
                m_we = r_sh_rd;
                m_wd = r_rd;
            end
            S_SHDN: begin
                // Delete: entry j+1 moves to j, working upwards.
                m_addr = r_sh_rd ? r_j[IdxW-1:0] : IdxW'(r_j + 1'b1);
                m_we = r_sh_rd;
                m_wd = r_rd;
            end
            S_WRITE: begin
                m_addr = r_pos[IdxW-1:0];
                m_we = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_verdict = r_verdict;
    assign o_matched = r_matched;
    assign o_matched_id = r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sh_rd <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_command;
                        r_ipp <= i_ip_protocol;
                        r_new <= '{id: i_rule_id,
                                   kind: {i_rule_action, i_rule_protocol},
                                   sa: i_src_addr, da: i_dst_addr,
                                   ports: {i_sport, i_dport}};
                        r_i <= '0;
                        r_pos <= r_count;
                        r_verdict <= 1'b0;
                        r_matched <= 1'b0;
                        r_mid <= '0;
                        case (i_command)
                            CmdAdd: r_status <= StAdded;
                            CmdCls: r_status <= StClassified;
                            default: r_status <= StNotFound;
                        endcase
                        if (i_command == CmdAdd || i_command == CmdDel
                            || i_command == CmdCls) begin
                            r_state <= (r_count == '0) ? S_WAIT : S_SCAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    // Address r_i is presented this cycle; data valid next.
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_i == r_count) begin
                        // Walk finished without an early exit.
                        if (r_cmd == CmdAdd) begin
                            if (r_count == CntW'(MaxRules)) begin
                                r_status <= StFull;
                                r_state <= S_OUT;
                            end else begin
                                r_j <= r_count;
                                r_sh_rd <= 1'b0;
                                r_state <= (r_count == r_pos) ? S_WRITE : S_SHUP;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        case (r_cmd)
                            CmdCls: begin
                                if (hit) begin
                                    r_matched <= 1'b1;
                                    r_mid <= r_rd.id;
                                    r_verdict <= r_rd.kind[2];
                                    r_state <= S_OUT;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            CmdDel: begin
                                if (r_rd.id == r_new.id) begin
                                    r_status <= StDeleted;
                                    r_count <= r_count - 1'b1;
                                    r_j <= r_i;
                                    r_sh_rd <= 1'b0;
                                    r_state <= (r_i + 1'b1 == r_count) ? S_OUT : S_SHDN;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                if (r_rd.id == r_new.id) begin
                                    r_pos <= r_i;
                                    if (same_body) begin
                                        r_status <= StDup;
                                        r_state <= S_OUT;
                                    end else begin
                                        r_status <= StUpdated;
                                        r_state <= S_WRITE;
                                    end
                                end else begin
                                    if (r_pos == r_count && r_rd.id > r_new.id) begin
                                        r_pos <= r_i;
                                    end
                                    r_i <= r_i + 1'b1;
                                    r_state <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                S_SHUP: begin
                    r_sh_rd <= !r_sh_rd;
                    if (r_sh_rd) begin
                        if (r_j - 1'b1 == r_pos) begin
                            r_state <= S_WRITE;
                        end
                        r_j <= r_j - 1'b1;
                    end
                end
                S_SHDN: begin
                    r_sh_rd <= !r_sh_rd;
                    if (r_sh_rd) begin
                        // r_count already holds the reduced count.
                        if (r_j + 1'b1 == r_count) begin
                            r_state <= S_OUT;
                        end
                        r_j <= r_j + 1'b1;
                    end
                end
                S_WRITE: begin
                    if (r_status == StAdded) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A delete has found its rule in this cycle.
    logic del_hit;
    assign del_hit = (r_state == S_WAIT) && (r_cmd == CmdDel) && (r_i != r_count)
        && (r_rd.id == r_new.id);

    // The table never holds more than its capacity.
    `ASSERT_NEVER(a_count_cap, i_clk, i_rst_n, r_count > CntW'(MaxRules))
    // A result is only offered once the input side is closed.
    `ASSERT_CLK(a_out_stall, i_clk, i_rst_n, o_valid |-> o_stall)
    // A completed delete has shrunk the table by one.
    `ASSERT_CLK(a_del_cnt, i_clk, i_rst_n, del_hit |=> r_count == $past(r_count) - 1'b1)
endmodule

/* rtl/core/ftrc_match.sv */
// ----------------------------------------------------------------------------
// ftrc_match
// Compares one stored rule against the packet held for classification.
// ----------------------------------------------------------------------------
module ftrc_match (
    input  ftrc_pkg::t_rule i_rule,
    input  logic [31:0]     i_sa,
    input  logic [31:0]     i_da,
    input  logic [15:0]     i_sp,
    input  logic [15:0]     i_dp,
    input  logic [7:0]      i_ipp,
    output logic            o_hit
);
    import ftrc_pkg::*;
    logic p_ok;
    logic [15:0] rsp, rdp, psp, pdp;
    logic port_proto;

    always_comb begin
        case (i_rule.kind[1:0])
            RpTcp:   p_ok = (i_ipp == ProtoTcp);
            RpUdp:   p_ok = (i_ipp == ProtoUdp);
            RpIcmp:  p_ok = (i_ipp == ProtoIcmp);
            default: p_ok = 1'b1;
        endcase
    end

    assign port_proto = (i_ipp == ProtoTcp) || (i_ipp == ProtoUdp);
    assign psp = port_proto ? i_sp : 16'd0;
    assign pdp = port_proto ? i_dp : 16'd0;
    assign rsp = i_rule.ports[31:16];
    assign rdp = i_rule.ports[15:0];
    assign o_hit = p_ok
        && (i_rule.sa == 32'd0 || i_rule.sa == i_sa)
        && (i_rule.da == 32'd0 || i_rule.da == i_da)
        && (rsp == 16'd0 || rsp == psp)
        && (rdp == 16'd0 || rdp == pdp);
endmodule
